/* rtl/madt_pkg.sv */
// Shared types, constants and codes of the MADT parser.
package madt_pkg;

  // Table layout
  localparam logic [31:0] ENTRIES_AT = 32'd44;
  localparam logic [31:0] LAPIC_AT   = 32'd36;
  localparam logic [31:0] HDR_SUMMED = 32'd8;
  localparam logic [31:0] LEN_FIRST  = 32'd4;
  localparam logic [31:0] LEN_LAST   = 32'd7;

  // Override flag masks
  localparam logic [3:0] POL_MASK  = 4'h3;
  localparam logic [3:0] TRIG_MASK = 4'hC;

  // Reset value of the vector base register
  localparam logic [7:0] VECTOR_RESET = 8'h30;

  // Entry types handled
  localparam logic [7:0] ENTRY_IO_APIC   = 8'd1;
  localparam logic [7:0] ENTRY_OVERRIDE  = 8'd2;
  localparam logic [7:0] ENTRY_LAPIC_OVR = 8'd5;

  // Record kinds
  localparam logic KIND_OVERRIDE = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  // Record queue depth
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_LOCAL  = 2'd1,
    STATUS_NO_IO     = 2'd2,
    STATUS_MALFORMED = 2'd3
  } status_t;

  // Input request: one table byte
  typedef struct packed {
    logic [7:0] table_byte;
    logic       table_start;
  } in_req_t;

  // Output record
  typedef struct packed {
    logic        record_kind;
    logic [7:0]  iso_bus;
    logic [7:0]  iso_source_irq;
    logic [31:0] iso_gsi;
    logic [1:0]  iso_polarity;
    logic [1:0]  iso_trigger;
    logic [7:0]  iso_vector;
    logic [63:0] local_apic_base;
    logic [31:0] io_apic_base;
    logic        checksum_ok;
    logic [1:0]  parse_status;
  } out_rec_t;

  // Outcome of one parsed byte, queued from front to back
  typedef struct packed {
    logic        has_ovr;
    logic        has_sum;
    logic [7:0]  ovr_bus;
    logic [7:0]  ovr_irq;
    logic [31:0] ovr_gsi;
    logic [3:0]  ovr_flags;
    logic [63:0] sum_local;
    logic [31:0] sum_io;
    logic        sum_zero;
    logic        sum_malformed;
  } pkt_t;

endpackage

/* rtl/madt_front.sv */
// Byte parser: tracks table offset, checksum and entry walk, builds record packets.
module madt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  madt_pkg::in_req_t in_data,
  output logic              push,
  output madt_pkg::pkt_t    push_pkt
);
  import madt_pkg::*;

  logic [31:0] off_r, off_nxt, off_c;
  logic [31:0] len_r, len_nxt, len_c;
  logic [7:0]  sum_r, sum_nxt, sum_c;
  logic [7:0]  pos_r, pos_nxt, pos_c;
  logic [7:0]  etype_r, etype_nxt, etype_c;
  logic [7:0]  elen_r, elen_nxt, elen_c;
  logic [63:0] fshift_r, fshift_nxt, fshift_c;
  logic [31:0] eword_r, eword_nxt, eword_c;
  logic [15:0] busirq_r, busirq_nxt, busirq_c;
  logic [63:0] local_r, local_nxt, local_c;
  logic [31:0] io_r, io_nxt, io_c;
  logic        malf_r, malf_nxt, malf_c;
  logic        clr;
  logic [7:0]  b;
  logic [31:0] end_old;
  logic        active;
  logic        emit_ovr, emit_sum;

  assign clr = in_data.table_start;
  assign b   = in_data.table_byte;

  // A start mark clears all parse state before this byte is taken
  assign off_c    = clr ? '0 : off_r;
  assign len_c    = clr ? '0 : len_r;
  assign sum_c    = clr ? '0 : sum_r;
  assign pos_c    = clr ? '0 : pos_r;
  assign etype_c  = clr ? '0 : etype_r;
  assign elen_c   = clr ? '0 : elen_r;
  assign fshift_c = clr ? '0 : fshift_r;
  assign eword_c  = clr ? '0 : eword_r;
  assign busirq_c = clr ? '0 : busirq_r;
  assign local_c  = clr ? '0 : local_r;
  assign io_c     = clr ? '0 : io_r;
  assign malf_c   = clr ? 1'b0 : malf_r;

  assign end_old = (len_c < ENTRIES_AT) ? ENTRIES_AT : len_c;
  assign active  = (off_c < end_old);

  // Per-byte parse step
  always_comb begin
    logic [31:0] end_new;
    logic [7:0]  pos_m4;
    off_nxt    = off_c;
    len_nxt    = len_c;
    sum_nxt    = sum_c;
    pos_nxt    = pos_c;
    etype_nxt  = etype_c;
    elen_nxt   = elen_c;
    fshift_nxt = fshift_c;
    eword_nxt  = eword_c;
    busirq_nxt = busirq_c;
    local_nxt  = local_c;
    io_nxt     = io_c;
    malf_nxt   = malf_c;
    emit_ovr   = 1'b0;
    emit_sum   = 1'b0;
    end_new    = end_old;
    pos_m4     = pos_c - 8'd4;
    if (active) begin
      // checksum span
      if (off_c < HDR_SUMMED || off_c < len_c) begin
        sum_nxt = sum_c + b;
      end
      // table length, little endian
      if (off_c >= LEN_FIRST && off_c <= LEN_LAST) begin
        len_nxt = len_c | (32'(b) << {off_c[1:0], 3'b000});
      end
      // local APIC address from the header
      if (off_c >= LAPIC_AT && off_c <= LAPIC_AT + 32'd3) begin
        local_nxt = local_c | (64'(b) << {off_c[1:0], 3'b000});
      end
      // entry walk
      if (off_c >= ENTRIES_AT && !malf_c) begin
        if (pos_c == 8'd0) begin
          etype_nxt  = b;
          fshift_nxt = '0;
          eword_nxt  = '0;
          busirq_nxt = '0;
          pos_nxt    = 8'd1;
        end else if (pos_c == 8'd1 && b < 8'd2) begin
          elen_nxt = b;
          malf_nxt = 1'b1;
        end else begin
          if (pos_c == 8'd1) begin
            elen_nxt = b;
          end else begin
            case (etype_c)
              ENTRY_IO_APIC: begin
                if (pos_c >= 8'd4 && pos_c <= 8'd7) begin
                  fshift_nxt = fshift_c | (64'(b) << {pos_c[1:0], 3'b000});
                end else if (pos_c >= 8'd8 && pos_c <= 8'd11) begin
                  eword_nxt = eword_c | (32'(b) << {pos_c[1:0], 3'b000});
                end
                if (pos_c == 8'd11 && eword_nxt == 32'd0) begin
                  io_nxt = fshift_c[31:0];
                end
              end
              ENTRY_OVERRIDE: begin
                if (pos_c == 8'd2) begin
                  busirq_nxt = busirq_c | {8'd0, b};
                end else if (pos_c == 8'd3) begin
                  busirq_nxt = busirq_c | {b, 8'd0};
                end else if (pos_c >= 8'd4 && pos_c <= 8'd7) begin
                  eword_nxt = eword_c | (32'(b) << {pos_c[1:0], 3'b000});
                end else if (pos_c == 8'd8) begin
                  fshift_nxt = 64'(b);
                end else if (pos_c == 8'd9) begin
                  emit_ovr = 1'b1;
                end
              end
              ENTRY_LAPIC_OVR: begin
                if (pos_c >= 8'd4 && pos_c <= 8'd11) begin
                  fshift_nxt = fshift_c | (64'(b) << {pos_m4[2:0], 3'b000});
                end
                if (pos_c == 8'd11) begin
                  local_nxt = fshift_nxt;
                end
              end
              default: ;
            endcase
          end
          // entry end: position back to zero
          if ({1'b0, pos_c} + 9'd1 >= {1'b0, elen_nxt}) begin
            pos_nxt = 8'd0;
          end else begin
            pos_nxt = pos_c + 8'd1;
          end
        end
      end
      off_nxt = off_c + 32'd1;
      end_new = (len_nxt < ENTRIES_AT) ? ENTRIES_AT : len_nxt;
      // last table byte: summary
      if (off_nxt == end_new) begin
        emit_sum = 1'b1;
        if (len_nxt < ENTRIES_AT) begin
          malf_nxt = 1'b1;
        end
      end
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r    <= '0;
      len_r    <= '0;
      sum_r    <= '0;
      pos_r    <= '0;
      etype_r  <= '0;
      elen_r   <= '0;
      fshift_r <= '0;
      eword_r  <= '0;
      busirq_r <= '0;
      local_r  <= '0;
      io_r     <= '0;
      malf_r   <= 1'b0;
    end else if (in_fire) begin
      off_r    <= off_nxt;
      len_r    <= len_nxt;
      sum_r    <= sum_nxt;
      pos_r    <= pos_nxt;
      etype_r  <= etype_nxt;
      elen_r   <= elen_nxt;
      fshift_r <= fshift_nxt;
      eword_r  <= eword_nxt;
      busirq_r <= busirq_nxt;
      local_r  <= local_nxt;
      io_r     <= io_nxt;
      malf_r   <= malf_nxt;
    end
  end

  // Packet toward the record queue
  assign push = in_fire && (emit_ovr || emit_sum);

  always_comb begin
    push_pkt               = '0;
    push_pkt.has_ovr       = emit_ovr;
    push_pkt.has_sum       = emit_sum;
    push_pkt.ovr_bus       = busirq_c[7:0];
    push_pkt.ovr_irq       = busirq_c[15:8];
    push_pkt.ovr_gsi       = eword_c;
    push_pkt.ovr_flags     = fshift_c[3:0];
    push_pkt.sum_local     = local_nxt;
    push_pkt.sum_io        = io_nxt;
    push_pkt.sum_zero      = (sum_nxt == 8'd0);
    push_pkt.sum_malformed = malf_nxt;
  end

endmodule

/* rtl/madt_queue.sv */
// Short packet queue between the byte parser and the record formatter.
module madt_queue #(
  parameter int Depth = madt_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  madt_pkg::pkt_t push_pkt,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output madt_pkg::pkt_t head_pkt
);
  import madt_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pkt_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full     = (count_r == CntW'(Depth));
  assign empty    = (count_r == '0);
  assign head_pkt = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth)) else $error("queue count out of range");
`endif

endmodule

/* rtl/madt_back.sv */
// Record formatter: vector base register, override and summary records, output register.
module madt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic               empty,
  input  madt_pkg::pkt_t     head_pkt,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output madt_pkg::out_rec_t out_data
);
  import madt_pkg::*;

  logic [7:0] vector_base_r;
  logic       out_valid_r, out_valid_nxt;
  out_rec_t   out_data_r;
  logic       ovr_done_r, ovr_done_nxt;
  logic       load;
  logic       send_ovr;
  logic       last;
  out_rec_t   rec;
  status_t    status;

  // Vector base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_base_r <= VECTOR_RESET;
    end else if (cfg_we) begin
      vector_base_r <= cfg_data;
    end
  end

  // Which record of the head packet goes next
  assign send_ovr = head_pkt.has_ovr && !ovr_done_r;
  assign last     = !(send_ovr && head_pkt.has_sum);
  assign load     = !empty && (!out_valid_r || out_ready);
  assign pop      = load && last;

  // Status priority: malformed, no local base, no I/O base
  always_comb begin
    if (head_pkt.sum_malformed) begin
      status = STATUS_MALFORMED;
    end else if (head_pkt.sum_local == 64'd0) begin
      status = STATUS_NO_LOCAL;
    end else if (head_pkt.sum_io == 32'd0) begin
      status = STATUS_NO_IO;
    end else begin
      status = STATUS_OK;
    end
  end

  // Record build
  always_comb begin
    rec = '0;
    if (send_ovr) begin
      rec.record_kind    = KIND_OVERRIDE;
      rec.iso_bus        = head_pkt.ovr_bus;
      rec.iso_source_irq = head_pkt.ovr_irq;
      rec.iso_gsi        = head_pkt.ovr_gsi;
      rec.iso_polarity   = 2'(head_pkt.ovr_flags & POL_MASK);
      rec.iso_trigger    = 2'((head_pkt.ovr_flags & TRIG_MASK) >> 2);
      rec.iso_vector     = vector_base_r + head_pkt.ovr_irq;
    end else begin
      rec.record_kind     = KIND_SUMMARY;
      rec.local_apic_base = head_pkt.sum_local;
      rec.io_apic_base    = head_pkt.sum_io;
      rec.checksum_ok     = head_pkt.sum_zero;
      rec.parse_status    = status;
    end
  end

  // Control next state
  always_comb begin
    out_valid_nxt = out_valid_r;
    ovr_done_nxt  = ovr_done_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      ovr_done_nxt  = !last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ovr_done_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      ovr_done_r  <= ovr_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= rec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_sum_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.record_kind == KIND_SUMMARY
      |-> out_data_r.iso_gsi == 32'd0 && out_data_r.iso_source_irq == 8'd0)
    else $error("summary record carries override fields");
  a_split_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ovr_done_r |-> !empty && head_pkt.has_sum)
    else $error("override sent but summary of the packet is missing");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("output record changed while stalled");
`endif

endmodule

/* rtl/madt_apic_table_parser.sv */
// Top level of the streaming MADT parser.
//
//   port group  dir  handshake            payload
//   in_*        in   in_valid/in_ready    in_data   (madt_pkg::in_req_t)
//   out_*       out  out_valid/out_ready  out_data  (madt_pkg::out_rec_t)
//   cfg_*       in   cfg_we               cfg_data  (vector base, 8 bits)
//
// One table byte is accepted every cycle while the record queue has room;
// the byte parser does all per-byte work in the cycle that accepts the byte.
// A record passes through the queue storage and then the output register before it reaches
// out_data; a byte that yields an override and the summary gives two output records, override first.
// When out_ready stays low the queue absorbs up to Depth packets, then in_ready drops.
// Synchronous active-low reset clears parse state and sets the vector base to 48.
module madt_apic_table_parser #(
  parameter int Depth = madt_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  madt_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output madt_pkg::out_rec_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data
);
  import madt_pkg::*;

  logic in_fire;
  logic push, pop, full, empty;
  pkt_t push_pkt, head_pkt;

  assign in_ready = !full;
  assign in_fire  = in_valid && in_ready;

  madt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_data  (in_data),
    .push     (push),
    .push_pkt (push_pkt)
  );

  madt_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pkt (push_pkt),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head_pkt (head_pkt)
  );

  madt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .head_pkt  (head_pkt),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
